@@ rtl/mrm_pkg.sv @@
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types and constants of the message ring mailbox.
// ----------------------------------------------------------------------------
package mrm_pkg;

  localparam int SLOT_COUNT_DEF     = 8;
  localparam int MAX_MSG_BYTES_DEF  = 64;
  localparam int DATA_W             = 8;
  localparam int LEN_W              = 7;

  typedef enum logic [1:0] {
    KIND_SEND_BYTE  = 2'd0,
    KIND_SEND_EMPTY = 2'd1,
    KIND_RECV       = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [DATA_W-1:0]      data;
    logic                   valid;
    logic                   last;
    logic [LEN_W-1:0]       len;
  } mrm_result_t;

  // free result entries once this cycle's pop is taken into account
  typedef struct packed {
    logic [1:0] room;
  } mrm_oq_stat_t;

endpackage

@@ rtl/mrm_out_buf.sv @@
// ----------------------------------------------------------------------------
// mrm_out_buf
// Two-entry result queue between the mailbox core and the result channel.
// ----------------------------------------------------------------------------
module mrm_out_buf
  import mrm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  mrm_result_t  push_res,
  output mrm_oq_stat_t stat,
  output logic         out_valid,
  input  logic         out_ready,
  output mrm_result_t  out_res
);

  mrm_result_t ent_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign out_valid  = (cnt_r != 2'd0);
  assign pop        = out_valid && out_ready;
  assign out_res    = ent_r[rd_ptr_r];
  assign stat.room  = 2'(2'd2 - cnt_r + {1'b0, pop});

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = 2'(cnt_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

@@ rtl/message_ring_mailbox.sv @@
// ----------------------------------------------------------------------------
// message_ring_mailbox
// Ring of message slots with byte-wise send and streamed receive.
// ----------------------------------------------------------------------------
// The mailbox keeps up to SLOT_COUNT-1 messages of at most MAX_MESSAGE_BYTES
// bytes each in one byte memory of SLOT_COUNT*MAX_MESSAGE_BYTES entries, plus
// a small length memory with one entry per slot; both have a registered read.
// Send requests are taken while the result queue has room, so a message goes
// in at one byte per cycle, and the last byte (or a zero-length send) yields
// one status result. A receive reads the stored length from the length
// memory in S_IDLE and S_LEN, then streams min(length, max_len) bytes at one
// per cycle while the result queue has room, from the single read port of the
// byte memory, or one result when nothing is to be sent. The next request is
// taken once the last byte read has been handed to the result queue. No
// clearing pass follows reset; slots are only read after they were written.
// ----------------------------------------------------------------------------
module message_ring_mailbox
  import mrm_pkg::*;
#(
  parameter int SLOT_COUNT        = SLOT_COUNT_DEF,
  parameter int MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [DATA_W-1:0] in_data_in,
  input  logic              in_last_in,
  input  logic [LEN_W-1:0]  in_max_len,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [DATA_W-1:0] out_data_out,
  output logic              out_data_valid,
  output logic              out_last_out,
  output logic [LEN_W-1:0]  out_msg_len
);

  localparam int IW    = $clog2(SLOT_COUNT);
  localparam int BW    = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
  localparam int DEPTH = SLOT_COUNT * MAX_MESSAGE_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [LEN_W-1:0] MAXL   = LEN_W'(MAX_MESSAGE_BYTES);
  localparam logic [IW-1:0]    LAST_S = IW'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_STREAM
  } state_t;

  state_t           state_r, state_nxt;
  logic [IW-1:0]    head_r, head_nxt;
  logic [IW-1:0]    tail_r, tail_nxt;
  logic [LEN_W-1:0] gath_r, gath_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IW-1:0]    rslot_r, rslot_nxt;
  logic [LEN_W-1:0] maxl_r, maxl_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_last_r, pend_last_nxt;

  // memories
  logic [DATA_W-1:0] byte_mem [DEPTH];
  logic [DATA_W-1:0] bdata_r;
  logic [LEN_W-1:0]  len_mem [SLOT_COUNT];
  logic [LEN_W-1:0]  ldata_r;

  logic              bwe, bre, lwe, lre;
  logic [AW-1:0]     bwaddr, braddr;
  logic [LEN_W-1:0]  lwdata;

  logic              acc, full, ovf_eff, room_ok;
  logic [IW-1:0]     tail_inc, head_inc;
  logic [LEN_W-1:0]  gath_inc, len_clamp;
  logic              push;
  mrm_result_t       push_res, out_res;
  mrm_oq_stat_t      oq_stat;

  function automatic logic [LEN_W-1:0] gath_inc_idx(input logic [LEN_W-1:0] v);
    return LEN_W'(v + LEN_W'(1));
  endfunction

  assign tail_inc  = (tail_r == LAST_S) ? '0 : IW'(tail_r + IW'(1));
  assign head_inc  = (head_r == LAST_S) ? '0 : IW'(head_r + IW'(1));
  assign full      = (tail_inc == head_r);
  assign gath_inc  = LEN_W'(gath_r + LEN_W'(1));
  assign ovf_eff   = ovf_r || (gath_r >= MAXL);
  assign len_clamp = (ldata_r > MAXL) ? MAXL : ldata_r;
  assign room_ok   = (oq_stat.room != 2'd0);

  assign in_ready = (state_r == S_IDLE) && room_ok;
  assign acc      = in_valid && in_ready;

  assign bwaddr = AW'(AW'(tail_r) * AW'(MAX_MESSAGE_BYTES) + AW'(gath_r[BW-1:0]));
  assign braddr = AW'(AW'(rslot_r) * AW'(MAX_MESSAGE_BYTES) + AW'(idx_r[BW-1:0]));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    gath_nxt      = gath_r;
    ovf_nxt       = ovf_r;
    rslot_nxt     = rslot_r;
    maxl_nxt      = maxl_r;
    len_nxt       = len_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    bwe           = 1'b0;
    bre           = 1'b0;
    lwe           = 1'b0;
    lre           = 1'b0;
    lwdata        = '0;
    push          = 1'b0;
    push_res      = '{status: ST_OK, data: '0, valid: 1'b0, last: 1'b1, len: '0};

    // hand a returning byte to the result queue
    if (pend_r) begin
      push     = 1'b1;
      push_res = '{status: ST_OK, data: bdata_r, valid: 1'b1,
                   last: pend_last_r, len: len_r};
      if (pend_last_r) begin
        state_nxt = S_IDLE;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (kind_t'(in_kind))
            KIND_SEND_BYTE: begin
              if (gath_r < MAXL) begin
                bwe      = 1'b1;
                gath_nxt = gath_inc;
              end else begin
                ovf_nxt = 1'b1;
              end
              if (in_last_in) begin
                push = 1'b1;
                if (ovf_eff) begin
                  push_res.status = ST_TOO_LARGE;
                end else if (full) begin
                  push_res.status = ST_FULL;
                end else begin
                  lwe      = 1'b1;
                  lwdata   = gath_inc;
                  tail_nxt = tail_inc;
                end
                gath_nxt = '0;
                ovf_nxt  = 1'b0;
              end
            end
            KIND_SEND_EMPTY: begin
              gath_nxt = '0;
              ovf_nxt  = 1'b0;
              push     = 1'b1;
              if (full) begin
                push_res.status = ST_FULL;
              end else begin
                lwe      = 1'b1;
                tail_nxt = tail_inc;
              end
            end
            KIND_RECV: begin
              if (head_r == tail_r) begin
                push            = 1'b1;
                push_res.status = ST_EMPTY;
              end else begin
                lre       = 1'b1;
                rslot_nxt = head_r;
                head_nxt  = head_inc;
                maxl_nxt  = in_max_len;
                state_nxt = S_LEN;
              end
            end
            default: ;
          endcase
        end
      end
      S_LEN: begin
        len_nxt   = len_clamp;
        n_nxt     = (len_clamp < maxl_r) ? len_clamp : maxl_r;
        idx_nxt   = '0;
        state_nxt = S_STREAM;
      end
      S_STREAM: begin
        if (n_r == '0) begin
          if (room_ok) begin
            push         = 1'b1;
            push_res.len = len_r;
            state_nxt    = S_IDLE;
          end
        end else if ((idx_r < n_r) && (oq_stat.room > {1'b0, pend_r})) begin
          // issue the next byte read; it lands in the queue next cycle
          bre           = 1'b1;
          idx_nxt       = gath_inc_idx(idx_r);
          pend_nxt      = 1'b1;
          pend_last_nxt = (gath_inc_idx(idx_r) == n_r);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      gath_r      <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      gath_r      <= gath_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rslot_r <= rslot_nxt;
    maxl_r  <= maxl_nxt;
    len_r   <= len_nxt;
    n_r     <= n_nxt;
    idx_r   <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (bwe) begin
      byte_mem[bwaddr] <= in_data_in;
    end
    if (bre) begin
      bdata_r <= byte_mem[braddr];
    end
  end

  always_ff @(posedge clk) begin
    if (lwe) begin
      len_mem[tail_r] <= lwdata;
    end
    if (lre) begin
      ldata_r <= len_mem[head_r];
    end
  end

  mrm_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .stat      (oq_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status     = out_res.status;
  assign out_data_out   = out_res.data;
  assign out_data_valid = out_res.valid;
  assign out_last_out   = out_res.last;
  assign out_msg_len    = out_res.len;

endmodule
